>>> rtl/core/csts_pkg.sv
// Shared types and constants for the servo target smoother.
// Used by the channel interfaces and every module of the block; no dependencies.
`default_nettype none

package csts_pkg;

  localparam int unsigned MaxChannels = 16;
  localparam int unsigned ChW         = 4;
  localparam int unsigned AngW        = 8;
  localparam int unsigned CurW        = 16;
  localparam int unsigned PulseW      = 12;
  localparam int unsigned IdW         = 11;
  localparam int unsigned DlcW        = 4;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned GainW       = 8;
  localparam int unsigned NumBytes    = 8;
  localparam int unsigned NumPairs    = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 12;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [IdW-1:0]    MatchIdReset  = 11'd202;
  localparam logic [PulseW-1:0] PulseMinReset = 12'd160;
  localparam logic [PulseW-1:0] PulseMaxReset = 12'd505;
  localparam logic [GainW-1:0]  GainReset     = 8'd13;
  localparam logic [PulseW-1:0] PulseSat      = 12'd4095;

  localparam logic [AngW-1:0] ResetTargets [MaxChannels] = '{
    8'd150, 8'd45, 8'd0, 8'd0, 8'd0, 8'd0, 8'd45, 8'd85,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd99, 8'd5
  };

  // floor(x / 180) = (x * Recip180) >> Recip180Shift, exact for x below 2^20.
  localparam int unsigned Recip180Shift = 28;
  localparam logic [20:0] Recip180      = 21'd1491309;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMatchId  = 2'd0,
    CfgPulseMin = 2'd1,
    CfgPulseMax = 2'd2,
    CfgGain     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkStep,
    BkMap,
    BkDiv,
    BkEmit
  } bk_state_e;

  // A classified command: either a tick or a set of target writes.
  typedef struct packed {
    logic                               is_tick;
    logic [NumPairs-1:0]                pair_vld;
    logic [NumPairs-1:0][ChW-1:0]       pair_ch;
    logic [NumPairs-1:0][AngW-1:0]      pair_ang;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/csts_item_if.sv
// Input channel: frame or tick item with valid/ready handshake.
// Depends on csts_pkg for field widths.
`default_nettype none

interface csts_item_if import csts_pkg::*;;
  logic              valid;
  logic              ready;
  logic              op;
  logic [IdW-1:0]    frame_id;
  logic [DlcW-1:0]   byte_count;
  logic [ByteW-1:0]  data0;
  logic [ByteW-1:0]  data1;
  logic [ByteW-1:0]  data2;
  logic [ByteW-1:0]  data3;
  logic [ByteW-1:0]  data4;
  logic [ByteW-1:0]  data5;
  logic [ByteW-1:0]  data6;
  logic [ByteW-1:0]  data7;

  modport source (output valid, op, frame_id, byte_count, data0, data1, data2, data3,
                  data4, data5, data6, data7, input ready);
  modport sink (input valid, op, frame_id, byte_count, data0, data1, data2, data3,
                data4, data5, data6, data7, output ready);
endinterface

`default_nettype wire

>>> rtl/core/csts_result_if.sv
// Output channel: one pulse update item per moved channel.
// Depends on csts_pkg for field widths.
`default_nettype none

interface csts_result_if import csts_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ChW-1:0]    channel;
  logic [PulseW-1:0] pulse_count;
  logic              last;

  modport source (output valid, channel, pulse_count, last, input ready);
  modport sink (input valid, channel, pulse_count, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/csts_front.sv
// Front end: accepts input items, filters frames by id and turns them into commands.
// Depends on csts_pkg and csts_item_if.
`default_nettype none

module csts_front import csts_pkg::*; #(
  parameter int unsigned Channels = MaxChannels
) (
  csts_item_if.sink      in_if,
  input  logic [IdW-1:0] match_id_i,
  input  logic           full_i,
  output logic           push_o,
  output cmd_t           cmd_o
);

  logic [ByteW-1:0] bytes [NumBytes];
  logic [DlcW-1:0]  cnt;
  logic [2:0]       pairs;
  logic             id_hit;

  assign bytes[0] = in_if.data0;
  assign bytes[1] = in_if.data1;
  assign bytes[2] = in_if.data2;
  assign bytes[3] = in_if.data3;
  assign bytes[4] = in_if.data4;
  assign bytes[5] = in_if.data5;
  assign bytes[6] = in_if.data6;
  assign bytes[7] = in_if.data7;

  assign cnt    = (in_if.byte_count > DlcW'(NumBytes)) ? DlcW'(NumBytes) : in_if.byte_count;
  assign pairs  = cnt[3:1];
  assign id_hit = (in_if.frame_id == match_id_i);

  always_comb begin
    cmd_o.is_tick = in_if.op;
    for (int k = 0; k < NumPairs; k++) begin
      cmd_o.pair_ch[k]  = bytes[2*k][ChW-1:0];
      cmd_o.pair_ang[k] = bytes[2*k+1];
      cmd_o.pair_vld[k] = !in_if.op && id_hit && (3'(k) < pairs) &&
                          (bytes[2*k] < ByteW'(Channels));
    end
  end

  assign in_if.ready = !full_i;
  // Frames with no valid pair are taken and dropped here.
  assign push_o = in_if.valid && !full_i && (cmd_o.is_tick || (|cmd_o.pair_vld));

endmodule

`default_nettype wire

>>> rtl/core/csts_queue.sv
// Short command queue between the front end and the channel walker.
// Depends on csts_pkg for the command type and depth.
`default_nettype none

module csts_queue import csts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t                  mem_q [QueueDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]         count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/csts_back.sv
// Back end: applies target writes and walks the channels on a tick, products split
// over the walk states, into a registered result. Depends on csts_pkg, csts_result_if.
`default_nettype none

module csts_back import csts_pkg::*; #(
  parameter int unsigned Channels = MaxChannels
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  logic [PulseW-1:0] pulse_min_i,
  input  logic [PulseW-1:0] pulse_max_i,
  input  logic [GainW-1:0]  gain_i,
  csts_result_if.source     out_if
);

  bk_state_e state_q, state_d;
  logic [ChW-1:0]  s_q, s_d;
  logic [AngW-1:0] tgt_q [Channels];
  logic [CurW-1:0] cur_q [Channels];

  logic signed [25:0] prod_q;
  logic signed [20:0] prod2_q;
  logic [30:0]        pp_lo_q;
  logic [29:0]        pp_hi_q;
  logic               neg_q;
  logic               last_q;

  logic              out_vld_q;
  logic [ChW-1:0]    out_ch_q;
  logic [PulseW-1:0] out_pulse_q;
  logic              out_last_q;

  logic [Channels-1:0] differ;
  logic [Channels-1:0] above;
  logic [AngW-1:0]     sel_tgt;
  logic [CurW-1:0]     sel_cur;
  logic signed [16:0]  diff;
  logic signed [25:0]  prod_d;
  logic signed [17:0]  step;
  logic [CurW-1:0]     new_cur;
  logic signed [12:0]  span;
  logic signed [20:0]  prod2_d;
  logic [19:0]         mag;
  logic [41:0]         full_prod;
  logic [13:0]         qmag;
  logic signed [14:0]  pulse_raw;
  logic [PulseW-1:0]   pulse_sat;
  logic                out_free;
  logic                at_end;
  logic                load_out;
  logic                cur_we;
  logic                frame_we;

  always_comb begin
    sel_tgt = '0;
    sel_cur = '0;
    for (int i = 0; i < Channels; i++) begin
      differ[i] = (cur_q[i] != {tgt_q[i], 8'd0});
      above[i]  = (ChW'(i) > s_q);
      if (s_q == ChW'(i)) begin
        sel_tgt = tgt_q[i];
        sel_cur = cur_q[i];
      end
    end
  end

  assign diff   = $signed({1'b0, sel_tgt, 8'd0}) - $signed({1'b0, sel_cur});
  assign prod_d = {{9{diff[16]}}, diff} * $signed({18'd0, gain_i});

  // Quotient by 256 truncated toward zero.
  assign step = prod_q[25] ? 18'((prod_q + 26'sd255) >>> 8) : prod_q[25:8];

  always_comb begin
    logic [16:0] sum;
    sum = 17'({1'b0, sel_cur}) + 17'(step);
    if (step == '0) begin
      new_cur = {sel_tgt, 8'd0};
    end else begin
      new_cur = sum[CurW-1:0];
    end
  end

  assign span    = $signed({1'b0, pulse_max_i}) - $signed({1'b0, pulse_min_i});
  assign prod2_d = $signed({13'd0, new_cur[15:8]}) * {{8{span[12]}}, span};

  assign mag       = prod2_q[20] ? 20'(-prod2_q) : 20'(prod2_q);
  assign full_prod = {1'b0, pp_hi_q, 11'd0} + {11'd0, pp_lo_q};
  assign qmag      = full_prod[41:Recip180Shift];
  assign pulse_raw = $signed({3'd0, pulse_min_i}) +
                     (neg_q ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag}));

  always_comb begin
    if (pulse_raw < 0) begin
      pulse_sat = '0;
    end else if (pulse_raw > $signed({3'd0, PulseSat})) begin
      pulse_sat = PulseSat;
    end else begin
      pulse_sat = pulse_raw[PulseW-1:0];
    end
  end

  assign out_free = !out_vld_q || out_if.ready;
  assign at_end   = (s_q == ChW'(Channels-1));

  always_comb begin
    state_d  = state_q;
    s_d      = s_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    cur_we   = 1'b0;
    frame_we = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.is_tick) begin
            state_d = BkStep;
            s_d     = '0;
          end else begin
            frame_we = 1'b1;
          end
        end
      end
      BkStep: begin
        if (differ[s_q]) begin
          state_d = BkMap;
        end else if (at_end) begin
          state_d = BkIdle;
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      BkMap: begin
        cur_we  = 1'b1;
        state_d = BkDiv;
      end
      BkDiv: begin
        state_d = BkEmit;
      end
      BkEmit: begin
        if (out_free) begin
          load_out = 1'b1;
          if (at_end || last_q) begin
            state_d = BkIdle;
          end else begin
            state_d = BkStep;
            s_d     = s_q + 1'b1;
          end
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BkIdle;
      s_q       <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < Channels; i++) begin
        tgt_q[i] <= ResetTargets[i];
        cur_q[i] <= {ResetTargets[i], 8'd0};
      end
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_q <= 1'b0;
      end
      // Later pairs of a frame overwrite earlier ones on the same channel.
      if (frame_we) begin
        for (int k = 0; k < NumPairs; k++) begin
          for (int i = 0; i < Channels; i++) begin
            if (cmd_i.pair_vld[k] && cmd_i.pair_ch[k] == ChW'(i)) begin
              tgt_q[i] <= cmd_i.pair_ang[k];
            end
          end
        end
      end
      if (cur_we) begin
        for (int i = 0; i < Channels; i++) begin
          if (s_q == ChW'(i)) begin
            cur_q[i] <= new_cur;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BkStep) begin
      prod_q <= prod_d;
      // Only the current channel changes during a walk, so this mask holds.
      last_q <= !(|(differ & above));
    end
    if (cur_we) begin
      prod2_q <= prod2_d;
    end
    if (state_q == BkDiv) begin
      neg_q   <= prod2_q[20];
      pp_lo_q <= mag * Recip180[10:0];
      pp_hi_q <= mag * Recip180[20:11];
    end
    if (load_out) begin
      out_ch_q    <= s_q;
      out_pulse_q <= pulse_sat;
      out_last_q  <= last_q || at_end;
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.channel     = out_ch_q;
  assign out_if.pulse_count = out_pulse_q;
  assign out_if.last        = out_last_q;

endmodule

`default_nettype wire

>>> rtl/core/can_servo_target_smoother.sv
// Servo target smoother: sixteen-channel angle ramp driven by command frames
// and update ticks, producing pulse on-counts.
//
// Input channel in_if takes an item when valid and ready are high. A frame item
// (op 0) whose frame_id equals match_id sets target angles of up to four
// channels; other frames are taken and dropped. A tick item (op 1) moves every
// channel whose current angle differs from its target and emits one item per
// moved channel on out_if, in ascending channel order, last set on the final.
// Accepted commands wait in a two-entry queue; ready is low only while it is full.
// A frame is applied at the edge it leaves the queue, at the earliest in the cycle after
// it is taken. A tick leaves the queue from the idle state, then walks the channels in
// order: a channel at rest is only checked, a moving one steps through product,
// position update, reciprocal multiply and result load. The walk stops after the last
// moving channel. Results sit in one output register; while the receiver stalls, the
// walk holds at its load step.
// The user must write configuration (cfg_we_i, cfg_idx_i, cfg_data_i) only while idle; not enforced.
// Reset restores the default targets, positions and register values at once.
// Depends on csts_pkg, csts_item_if, csts_result_if, csts_front, csts_queue, csts_back.
`default_nettype none

module can_servo_target_smoother import csts_pkg::*; #(
  parameter int unsigned Channels = MaxChannels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  csts_item_if.sink           in_if,
  csts_result_if.source       out_if
);

  logic [IdW-1:0]    match_id_q;
  logic [PulseW-1:0] pulse_min_q;
  logic [PulseW-1:0] pulse_max_q;
  logic [GainW-1:0]  gain_q;

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_id_q  <= MatchIdReset;
      pulse_min_q <= PulseMinReset;
      pulse_max_q <= PulseMaxReset;
      gain_q      <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMatchId:  match_id_q  <= cfg_data_i[IdW-1:0];
        CfgPulseMin: pulse_min_q <= cfg_data_i[PulseW-1:0];
        CfgPulseMax: pulse_max_q <= cfg_data_i[PulseW-1:0];
        CfgGain:     gain_q      <= cfg_data_i[GainW-1:0];
        default:     ;
      endcase
    end
  end

  csts_front #(
    .Channels (Channels)
  ) u_front (
    .in_if      (in_if),
    .match_id_i (match_id_q),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  csts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  csts_back #(
    .Channels (Channels)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .pulse_min_i (pulse_min_q),
    .pulse_max_i (pulse_max_q),
    .gain_i      (gain_q),
    .out_if      (out_if)
  );

endmodule

`default_nettype wire

>>> tb/can_servo_target_smoother_test.sv
// Self-checking testbench for can_servo_target_smoother: directed table, then random phases.
// Predicts pulse items from its own copy of the servo state or the table, and checks them in order.
// Depends on csts_pkg, csts_item_if, csts_result_if and the block itself.

module can_servo_target_smoother_test;
  import csts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OpFrame = 1'b0;
  localparam logic OpTick  = 1'b1;

  // The drain margin covers a full walk for each of the three commands that can be in flight.
  localparam int DrainCycles = 3 * 4 * MaxChannels + 16;
  localparam int LongHold    = 300;
  localparam int RandomItems = 86;
  localparam int TimeoutNs   = 5_000_000;

  typedef struct packed {
    logic                         op;
    logic [IdW-1:0]               frame_id;
    logic [DlcW-1:0]              byte_count;
    logic [NumBytes-1:0][ByteW-1:0] data;
  } servo_item_t;

  typedef struct packed {
    logic [ChW-1:0]    channel;
    logic [PulseW-1:0] pulse_count;
    logic              last;
  } pulse_t;

  typedef struct {
    bit                  is_cfg;
    cfg_idx_e            idx;
    logic [CfgDataW-1:0] value;
    servo_item_t         item;
    bit                  fixed;
    int unsigned         n_fixed;
    pulse_t              fixed_res [2];
  } plan_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  csts_item_if   item_ch ();
  csts_result_if pulse_ch ();

  can_servo_target_smoother dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (item_ch.sink),
    .out_if     (pulse_ch.source)
  );

  // Predicted copy of the block's registers and servo state.
  logic [IdW-1:0]    match_id_r;
  logic [PulseW-1:0] pulse_min_r;
  logic [PulseW-1:0] pulse_max_r;
  logic [GainW-1:0]  gain_r;
  logic [AngW-1:0]   target_deg   [MaxChannels];
  logic [CurW-1:0]   position_q88 [MaxChannels];

  pulse_t    step_pulses [$];
  pulse_t    pulse_exp_q [$];
  plan_row_t plan [$];

  int unsigned errors = 0;
  int          idle_pct = 0;
  bit          calm = 1'b0;
  int          hold_asked = 0;
  pulse_t      seen, want;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #TimeoutNs;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Frames update targets; a tick moves each channel toward its target and fills step_pulses.
  function automatic void advance_servos(input servo_item_t it);
    int unsigned n_pairs;
    int goal, pos, diff, delta, span, pulse;
    logic [ByteW-1:0] ch;
    pulse_t res;
    step_pulses.delete();
    if (it.op == OpFrame) begin
      if (it.frame_id != match_id_r) return;
      n_pairs = (it.byte_count > 4'd8) ? NumPairs : int'(unsigned'(it.byte_count)) / 2;
      for (int k = 0; k < n_pairs; k++) begin
        ch = it.data[2*k];
        if (ch < MaxChannels) target_deg[ch[ChW-1:0]] = it.data[2*k+1];
      end
    end else begin
      for (int s = 0; s < MaxChannels; s++) begin
        goal = int'(unsigned'(target_deg[s])) * 256;
        pos  = int'(unsigned'(position_q88[s]));
        if (pos == goal) continue;
        diff  = goal - pos;
        delta = (diff * int'(unsigned'(gain_r))) / 256;
        pos   = (delta == 0) ? goal : pos + delta;
        position_q88[s] = pos[CurW-1:0];
        span  = int'(unsigned'(pulse_max_r)) - int'(unsigned'(pulse_min_r));
        pulse = int'(unsigned'(pulse_min_r)) + ((pos >>> 8) * span) / 180;
        if (pulse < 0) pulse = 0;
        else if (pulse > 4095) pulse = 4095;
        res.channel     = ChW'(s);
        res.pulse_count = PulseW'(pulse);
        res.last        = 1'b0;
        step_pulses.push_back(res);
      end
      if (step_pulses.size() != 0) step_pulses[step_pulses.size()-1].last = 1'b1;
    end
  endfunction

  function automatic plan_row_t frame_row(input int id, input int dlc,
                                          input int c0, input int a0, input int c1, input int a1,
                                          input int c2, input int a2, input int c3, input int a3);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.fixed  = 1'b0;
    r.item.op         = OpFrame;
    r.item.frame_id   = IdW'(id);
    r.item.byte_count = DlcW'(dlc);
    r.item.data[0] = ByteW'(c0);
    r.item.data[1] = ByteW'(a0);
    r.item.data[2] = ByteW'(c1);
    r.item.data[3] = ByteW'(a1);
    r.item.data[4] = ByteW'(c2);
    r.item.data[5] = ByteW'(a2);
    r.item.data[6] = ByteW'(c3);
    r.item.data[7] = ByteW'(a3);
    return r;
  endfunction

  function automatic plan_row_t tick_row(input bit fixed, input int unsigned n,
                                         input pulse_t r0, input pulse_t r1);
    plan_row_t r;
    r.is_cfg       = 1'b0;
    r.item         = '0;
    r.item.op      = OpTick;
    r.fixed        = fixed;
    r.n_fixed      = n;
    r.fixed_res[0] = r0;
    r.fixed_res[1] = r1;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input cfg_idx_e idx, input int value);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.fixed  = 1'b0;
    r.idx    = idx;
    r.value  = CfgDataW'(value);
    return r;
  endfunction

  function automatic servo_item_t random_item();
    servo_item_t it;
    it.op         = ($urandom_range(0, 99) < 35) ? OpTick : OpFrame;
    it.frame_id   = ($urandom_range(0, 9) < 7) ? match_id_r : IdW'($urandom_range(0, 2047));
    it.byte_count = ($urandom_range(0, 9) < 6) ? 4'd8 : DlcW'($urandom_range(0, 15));
    for (int k = 0; k < NumBytes; k++) begin
      if (k % 2 == 0 && $urandom_range(0, 9) < 9) it.data[k] = ByteW'($urandom_range(0, 15));
      else it.data[k] = ByteW'($urandom_range(0, 255));
    end
    return it;
  endfunction

  // Offers one item, waits for its handshake and records what it should produce.
  task automatic offer(input plan_row_t r);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    item_ch.valid      <= 1'b1;
    item_ch.op         <= r.item.op;
    item_ch.frame_id   <= r.item.frame_id;
    item_ch.byte_count <= r.item.byte_count;
    item_ch.data0      <= r.item.data[0];
    item_ch.data1      <= r.item.data[1];
    item_ch.data2      <= r.item.data[2];
    item_ch.data3      <= r.item.data[3];
    item_ch.data4      <= r.item.data[4];
    item_ch.data5      <= r.item.data[5];
    item_ch.data6      <= r.item.data[6];
    item_ch.data7      <= r.item.data[7];
    do @(posedge clk_i); while (!item_ch.ready);
    advance_servos(r.item);
    if (r.fixed) begin
      for (int i = 0; i < r.n_fixed; i++) pulse_exp_q.push_back(r.fixed_res[i]);
    end else begin
      foreach (step_pulses[i]) pulse_exp_q.push_back(step_pulses[i]);
    end
  endtask

  // Registers change only once the block has drained and gone quiet.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    item_ch.valid <= 1'b0;
    while (pulse_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMatchId:  match_id_r  = value[IdW-1:0];
      CfgPulseMin: pulse_min_r = value;
      CfgPulseMax: pulse_max_r = value;
      CfgGain:     gain_r      = value[GainW-1:0];
      default: ;
    endcase
  endtask

  function automatic void report_mismatch(input string field, input int exp_v, input int got_v);
    errors++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && pulse_ch.valid && pulse_ch.ready) begin
      seen = '{pulse_ch.channel, pulse_ch.pulse_count, pulse_ch.last};
      if (pulse_exp_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected item, expected none, actual ch %0d pulse %0d last %0d",
                 $time, seen.channel, seen.pulse_count, seen.last);
      end else begin
        want = pulse_exp_q.pop_front();
        if (seen.channel !== want.channel)
          report_mismatch("channel", int'(want.channel), int'(seen.channel));
        if (seen.pulse_count !== want.pulse_count)
          report_mismatch("pulse_count", int'(want.pulse_count), int'(seen.pulse_count));
        if (seen.last !== want.last)
          report_mismatch("last", int'(want.last), int'(seen.last));
      end
    end
  end

  // Receiver side: random stalls, a long hold on request, and none at all when calm.
  initial begin
    int hold_done;
    hold_done = 0;
    pulse_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        pulse_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (calm) begin
        pulse_ch.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        pulse_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
        if ($urandom_range(0, 1) == 0) begin
          pulse_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    plan_row_t   row;
    servo_item_t burst;
    int          m, lo, hi, g;

    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CfgMatchId;
    cfg_data_i         <= '0;
    item_ch.valid      <= 1'b0;
    item_ch.op         <= OpFrame;
    item_ch.frame_id   <= '0;
    item_ch.byte_count <= '0;
    item_ch.data0      <= '0;
    item_ch.data1      <= '0;
    item_ch.data2      <= '0;
    item_ch.data3      <= '0;
    item_ch.data4      <= '0;
    item_ch.data5      <= '0;
    item_ch.data6      <= '0;
    item_ch.data7      <= '0;

    match_id_r  = MatchIdReset;
    pulse_min_r = PulseMinReset;
    pulse_max_r = PulseMaxReset;
    gain_r      = GainReset;
    for (int i = 0; i < MaxChannels; i++) begin
      target_deg[i]   = ResetTargets[i];
      position_q88[i] = {ResetTargets[i], 8'h00};
    end

    // Out of reset every channel rests on its target, so the first tick is silent.
    plan.push_back(tick_row(1'b1, 0, '0, '0));
    plan.push_back(frame_row(202, 8, 0, 0, 1, 255, 16, 7, 255, 9));
    plan.push_back(frame_row(203, 8, 2, 200, 3, 200, 4, 200, 5, 200));
    plan.push_back(frame_row(202, 15, 2, 90, 3, 180, 4, 1, 5, 255));
    plan.push_back(frame_row(202, 3, 6, 10, 7, 20, 8, 30, 9, 40));
    plan.push_back(frame_row(202, 0, 8, 99, 9, 99, 10, 99, 11, 99));
    plan.push_back(frame_row(202, 1, 12, 77, 13, 77, 0, 0, 0, 0));
    repeat (3) plan.push_back(tick_row(1'b0, 0, '0, '0));
    // With zero gain every move snaps, and a 0..180 span makes the pulse equal the angle.
    plan.push_back(cfg_row(CfgMatchId, 0));
    plan.push_back(cfg_row(CfgPulseMin, 0));
    plan.push_back(cfg_row(CfgPulseMax, 180));
    plan.push_back(cfg_row(CfgGain, 0));
    plan.push_back(tick_row(1'b0, 0, '0, '0));
    plan.push_back(tick_row(1'b1, 0, '0, '0));
    plan.push_back(frame_row(0, 4, 3, 255, 15, 180, 0, 0, 0, 0));
    plan.push_back(tick_row(1'b1, 2, '{4'd3, 12'd255, 1'b0}, '{4'd15, 12'd180, 1'b1}));
    plan.push_back(cfg_row(CfgMatchId, 2047));
    plan.push_back(cfg_row(CfgPulseMin, 4095));
    plan.push_back(cfg_row(CfgPulseMax, 4095));
    plan.push_back(cfg_row(CfgGain, 255));
    plan.push_back(frame_row(2047, 2, 3, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(tick_row(1'b0, 0, '0, '0));
    // A falling span drives the pulse below zero, a wide rising one above the top.
    plan.push_back(cfg_row(CfgPulseMax, 0));
    plan.push_back(frame_row(2047, 2, 0, 255, 0, 0, 0, 0, 0, 0));
    plan.push_back(tick_row(1'b0, 0, '0, '0));
    plan.push_back(cfg_row(CfgPulseMin, 0));
    plan.push_back(cfg_row(CfgPulseMax, 4095));
    repeat (2) plan.push_back(tick_row(1'b0, 0, '0, '0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].value);
      else offer(plan[i]);
    end

    row.is_cfg = 1'b0;
    row.fixed  = 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          m = $urandom_range(0, 2047); lo = $urandom_range(0, 600);
          hi = $urandom_range(200, 1200); g = 1;
        end
        1: begin m = 0; lo = 0; hi = 4095; g = 255; end
        2: begin m = 2047; lo = 4095; hi = 0; g = 0; end
        default: begin
          m = $urandom_range(0, 2047); lo = $urandom_range(0, 4095);
          hi = $urandom_range(0, 4095); g = $urandom_range(0, 255);
        end
      endcase
      write_reg(CfgMatchId, CfgDataW'(m));
      write_reg(CfgPulseMin, CfgDataW'(lo));
      write_reg(CfgPulseMax, CfgDataW'(hi));
      write_reg(CfgGain, CfgDataW'(g));

      if (phase == 0) begin
        // Slow gain keeps four channels moving while the receiver holds off and ticks pile up.
        burst.op         = OpFrame;
        burst.frame_id   = match_id_r;
        burst.byte_count = 4'd8;
        for (int k = 0; k < NumPairs; k++) begin
          burst.data[2*k]   = ByteW'(k);
          burst.data[2*k+1] = (position_q88[k][CurW-1:8] < 8'd128) ? 8'd255 : 8'd0;
        end
        row.item = burst;
        offer(row);
        hold_asked++;
        idle_pct  = 0;
        burst.op  = OpTick;
        row.item  = burst;
        repeat (14) offer(row);
      end

      if (phase == 3) begin
        calm     = 1'b1;
        idle_pct = 0;
      end else begin
        idle_pct = 25;
      end

      for (int n = 0; n < RandomItems; n++) begin
        if (n == RandomItems / 2) begin
          item_ch.valid <= 1'b0;
          do @(posedge clk_i); while (pulse_exp_q.size() != 0);
        end
        row.item = random_item();
        offer(row);
      end
    end

    item_ch.valid <= 1'b0;
    while (pulse_exp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
